/* rtl/core/msts_pkg.sv */
`default_nettype none

package msts_pkg;

	// Fixed field widths of the request and response beats
	localparam int ACT_W  = 3;
	localparam int SLOT_F = 3;
	localparam int DUR_W  = 48;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ENABLE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DURATION = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd4;

	// Response kinds
	localparam logic KIND_EXPIRY = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SLOT_F-1:0] slot;
		logic [DUR_W-1:0]  duration;
		logic              periodic;
		logic              enable;
		logic              rebase;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [SLOT_F-1:0] fired_slot;
		logic [DUR_W-1:0]  elapsed;
		logic [DUR_W-1:0]  time_left;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic first_rd;
		logic exec;
		logic flush;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic in_drop;
		logic is_tick;
		logic is_query;
		logic fire;
		logic pend_valid;
		logic out_free;
		logic scan_last;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/msts_ram.sv */
`default_nettype none

module msts_ram #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire  [AW-1:0]        waddr,
	input  wire  [WIDTH-1:0]     wdata,
	input  wire  [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/msts_ctrl.sv */
`default_nettype none

module msts_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  msts_pkg::sts_t sts,
	output msts_pkg::ctl_t ctl
);
	import msts_pkg::*;

	state_t state_q;
	state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx  = state_q;
		ctl       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.accept = 1'b1;
					state_nx   = sts.in_drop ? ST_IDLE : ST_READ;
				end
			end
			ST_READ: begin
				ctl.first_rd = 1'b1;
				state_nx     = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.is_tick) begin
					// hold while an older expiry has no room to leave
					if (!(sts.fire && sts.pend_valid && !sts.out_free)) begin
						ctl.exec = 1'b1;
						if (sts.scan_last) begin
							state_nx = ST_FLUSH;
						end
					end
				end else if (!(sts.is_query && !sts.out_free)) begin
					ctl.exec = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					state_nx = ST_IDLE;
				end else if (sts.out_free) begin
					ctl.flush = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/msts_dpath.sv */
`default_nettype none

module msts_dpath #(
	parameter int SLOTS     = 8,
	parameter int TIME_BITS = 48
) (
	input  wire            clk,
	input  wire            arst_n,
	input  msts_pkg::req_t req,
	input  wire            rsp_stall,
	output logic           rsp_valid,
	output msts_pkg::rsp_t rsp,
	input  msts_pkg::ctl_t ctl,
	output msts_pkg::sts_t sts
);
	import msts_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ROW_W  = 3 * TIME_BITS;

	req_t                 item_q;
	logic [TIME_BITS-1:0] now_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [SLOTS-1:0]     on_q;
	logic [SLOTS-1:0]     rep_q;
	logic [SLOTS-1:0]     vld_q;
	logic                 pend_q;
	logic [SLOT_W-1:0]    pend_slot_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 is_tick;
	logic                 is_query;
	logic [SLOT_W-1:0]    slot_idx;
	logic [SLOT_W-1:0]    cur;
	logic [TIME_BITS-1:0] dur;
	logic [TIME_BITS-1:0] dur_fix;
	logic [ROW_W-1:0]     row_rd;
	logic [TIME_BITS-1:0] start_rd;
	logic [TIME_BITS-1:0] exp_rd;
	logic [TIME_BITS-1:0] per_rd;
	logic                 fire;
	logic                 we;
	logic [ROW_W-1:0]     wdata;
	logic [SLOT_W-1:0]    raddr;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS:0]   left_diff;
	logic [TIME_BITS-1:0] time_left;
	logic                 out_free;
	logic                 ld_event;
	logic                 ld_query;

	// Decode the held beat
	assign is_tick  = (item_q.action == ACT_TICK);
	assign is_query = (item_q.action == ACT_QUERY);
	assign slot_idx = SLOT_W'(item_q.slot);
	assign cur      = is_tick ? idx_q : slot_idx;
	assign dur      = TIME_BITS'(item_q.duration);
	assign dur_fix  = (dur == '0) ? TIME_BITS'(1) : dur;

	// Slot times: one row {start, expiry, period} per slot
	msts_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SLOTS)
	) u_times (
		.clk   (clk),
		.we    (we),
		.waddr (cur),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (row_rd)
	);

	// Substitute reset values for rows never written
	assign start_rd = vld_q[cur] ? row_rd[ROW_W-1 -: TIME_BITS] : '0;
	assign exp_rd   = vld_q[cur] ? row_rd[2*TIME_BITS-1 -: TIME_BITS] : '1;
	assign per_rd   = vld_q[cur] ? row_rd[TIME_BITS-1:0] : '1;

	assign fire = on_q[cur] && (exp_rd < now_q);

	// Prefetch the next slot while the scan advances, else keep the current row
	always_comb begin
		if (ctl.first_rd) begin
			raddr = is_tick ? '0 : slot_idx;
		end else if (ctl.exec && is_tick) begin
			raddr = idx_q + SLOT_W'(1);
		end else begin
			raddr = cur;
		end
	end

	// Row update
	always_comb begin
		we    = 1'b0;
		wdata = {start_rd, exp_rd, per_rd};
		if (ctl.exec) begin
			case (item_q.action)
				ACT_TICK: begin
					if (fire && rep_q[cur]) begin
						we    = 1'b1;
						wdata = {exp_rd, exp_rd + per_rd, per_rd};
					end
				end
				ACT_START: begin
					we    = 1'b1;
					wdata = {now_q, now_q + dur_fix, dur_fix};
				end
				ACT_DURATION: begin
					we    = 1'b1;
					wdata = {start_rd, item_q.rebase ? start_rd + dur_fix : exp_rd, dur_fix};
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	// Query arithmetic
	assign elapsed   = now_q - start_rd;
	assign left_diff = {1'b0, exp_rd} - {1'b0, now_q};
	assign time_left = left_diff[TIME_BITS] ? '0 : left_diff[TIME_BITS-1:0];

	// Hold the beat, advance time and scan index
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			idx_q <= '0;
		end else if (ctl.accept) begin
			if (req.action == ACT_TICK) begin
				now_q <= now_q + TIME_BITS'(1);
				idx_q <= '0;
			end
		end else if (ctl.exec && is_tick) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
	end

	// Slot flags and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q  <= '0;
			rep_q <= '0;
			vld_q <= '0;
		end else if (ctl.exec) begin
			case (item_q.action)
				ACT_TICK: begin
					if (fire && !rep_q[cur]) begin
						on_q[cur] <= 1'b0;
					end
				end
				ACT_START: begin
					on_q[cur]  <= 1'b1;
					rep_q[cur] <= item_q.periodic;
					vld_q[cur] <= 1'b1;
				end
				ACT_ENABLE: begin
					on_q[cur] <= item_q.enable;
				end
				ACT_DURATION: begin
					rep_q[cur] <= item_q.periodic;
					vld_q[cur] <= 1'b1;
				end
				default: begin
					on_q <= on_q;
				end
			endcase
		end
	end

	// Keep one expiry back until the next one shows whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ctl.exec && is_tick && fire) begin
			pend_q <= 1'b1;
		end else if (ctl.flush) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && is_tick && fire) begin
			pend_slot_q <= cur;
		end
	end

	// Output register
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign ld_event = (ctl.exec && is_tick && fire && pend_q) || ctl.flush;
	assign ld_query = ctl.exec && is_query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ld_event || ld_query) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_query) begin
			rsp_q.kind       <= KIND_QUERY;
			rsp_q.fired_slot <= item_q.slot;
			rsp_q.elapsed    <= DUR_W'(elapsed);
			rsp_q.time_left  <= DUR_W'(time_left);
			rsp_q.last       <= 1'b1;
		end else if (ld_event) begin
			rsp_q.kind       <= KIND_EXPIRY;
			rsp_q.fired_slot <= SLOT_F'(pend_slot_q);
			rsp_q.elapsed    <= '0;
			rsp_q.time_left  <= '0;
			rsp_q.last       <= ctl.flush;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status to the controller
	always_comb begin
		sts.in_drop    = (req.action != ACT_TICK)
			&& ((req.action > ACT_QUERY) || ({29'd0, req.slot} >= 32'(SLOTS)));
		sts.is_tick    = is_tick;
		sts.is_query   = is_query;
		sts.fire       = fire;
		sts.pend_valid = pend_q;
		sts.out_free   = out_free;
		sts.scan_last  = (idx_q == SLOT_W'(SLOTS - 1));
	end

endmodule

`default_nettype wire

/* rtl/core/multi_slot_timer_scheduler_top.sv */
`default_nettype none

// Bank of SLOTS timers sharing one TIME_BITS-wide time counter. A tick beat
// advances the time and scans the slots from a time memory with one read
// port, one slot per cycle while the response side leaves room; its steps
// are accept, first read, scan and flush. Expiry beats come out in ascending
// slot order and the final one carries last. Start, enable, duration and
// query beats pass through accept, read and execute; a query returns one
// beat with last set. Undefined actions and slots at or above SLOTS are
// dropped in the accept cycle. Slot rows carry valid bits, so no clearing
// pass follows reset. The slot field is three bits wide, so only the first
// eight slots can be addressed.
module multi_slot_timer_scheduler_top #(
	parameter int SLOTS     = 8,
	parameter int TIME_BITS = 48
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  msts_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output msts_pkg::rsp_t rsp
);
	import msts_pkg::*;

	ctl_t ctl;
	sts_t sts;

	msts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	msts_dpath #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Commands are mutually exclusive
	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.accept, ctl.first_rd, ctl.exec, ctl.flush}))
		else $error("controller issued more than one command");

	// No expiry may be left over when a new beat comes in
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> !sts.pend_valid)
		else $error("held expiry not flushed before next beat");

	// Displacing a held expiry needs room in the output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && sts.is_tick && sts.fire && sts.pend_valid) |-> sts.out_free)
		else $error("expiry beat overwritten");

	// Flush only moves a held expiry into a free output register
	a_flush_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush |-> (sts.pend_valid && sts.out_free))
		else $error("flush without held expiry or room");

endmodule

`default_nettype wire
